[src/utf8d_pkg.sv]
package utf8d_pkg;

    // field widths
    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 2;
    localparam int LEN_W  = 3;

    // replacement character for a bad byte
    localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

    // sequence lengths told by a lead byte
    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // lead byte patterns
    localparam logic [BYTE_W-1:0] MASK_2  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_3  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_4  = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_4  = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT    = 8'h80;

    // results of one item: a run of replacements, then an optional tail result
    typedef struct packed {
        logic [CNT_W-1:0] nrep;
        logic             tail_vld;
        logic [CP_W-1:0]  tail_cp;
        logic             tail_rep;
        logic             str_end;
    } bundle_t;

    // length of the sequence a lead byte opens, zero if not a lead byte
    function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        len = LEN_NONE;
        if ((b & MASK_2) == LEAD_2) begin
            len = LEN_TWO;
        end else if ((b & MASK_3) == LEAD_3) begin
            len = LEN_THREE;
        end else if ((b & MASK_4) == LEAD_4) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

endpackage

[src/utf8d_decode.sv]
module utf8d_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
    input  logic                          str_end,
    input  logic                          fire,
    output utf8d_pkg::bundle_t            bundle,
    output logic                          has_result
);

    logic [utf8d_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [utf8d_pkg::LEN_W-1:0]  exp_reg, exp_next;
    logic [utf8d_pkg::BYTE_W-1:0] pb_reg [0:2];
    logic [utf8d_pkg::BYTE_W-1:0] pb_next [0:2];

    logic                         pend;
    logic                         cont;
    logic                         complete;
    logic [utf8d_pkg::LEN_W-1:0]  len;
    logic [utf8d_pkg::CP_W-1:0]   cp_full;

    assign pend = (cnt_reg != '0);
    assign cont = ((byte_in & utf8d_pkg::MASK_CONT) == utf8d_pkg::CONT);
    assign len  = utf8d_pkg::seq_len(byte_in);
    assign complete = pend && cont && (({1'b0, cnt_reg} + 3'd1) >= exp_reg);

    // assemble the code point of a finished sequence
    always_comb begin
        case (exp_reg)
            utf8d_pkg::LEN_TWO: begin
                cp_full = {10'd0, pb_reg[0][4:0], byte_in[5:0]};
            end
            utf8d_pkg::LEN_THREE: begin
                cp_full = {5'd0, pb_reg[0][3:0], pb_reg[1][5:0], byte_in[5:0]};
            end
            default: begin
                cp_full = {pb_reg[0][2:0], pb_reg[1][5:0], pb_reg[2][5:0], byte_in[5:0]};
            end
        endcase
    end

    // next state and results of the item in the input register
    always_comb begin
        cnt_next   = cnt_reg;
        exp_next   = exp_reg;
        pb_next[0] = pb_reg[0];
        pb_next[1] = pb_reg[1];
        pb_next[2] = pb_reg[2];
        bundle.nrep     = '0;
        bundle.tail_vld = 1'b0;
        bundle.tail_cp  = utf8d_pkg::REPL_CP;
        bundle.tail_rep = 1'b1;
        bundle.str_end  = str_end;

        if (complete) begin
            bundle.tail_vld = 1'b1;
            bundle.tail_cp  = cp_full;
            bundle.tail_rep = 1'b0;
            cnt_next = '0;
            exp_next = utf8d_pkg::LEN_NONE;
        end else if (pend && cont) begin
            // another continuation byte of an unfinished sequence
            case (cnt_reg)
                2'd1:    pb_next[1] = byte_in;
                default: pb_next[2] = byte_in;
            endcase
            cnt_next = cnt_reg + 2'd1;
            if (str_end) begin
                bundle.nrep     = cnt_reg;
                bundle.tail_vld = 1'b1;
                cnt_next = '0;
                exp_next = utf8d_pkg::LEN_NONE;
            end
        end else begin
            // broken sequence: each held byte is replaced
            bundle.nrep = cnt_reg;
            cnt_next = '0;
            exp_next = utf8d_pkg::LEN_NONE;
            // decode this byte as a fresh start
            if (!byte_in[7]) begin
                bundle.tail_vld = 1'b1;
                bundle.tail_cp  = {13'd0, byte_in};
                bundle.tail_rep = 1'b0;
            end else if (len != utf8d_pkg::LEN_NONE) begin
                pb_next[0] = byte_in;
                if (str_end) begin
                    bundle.tail_vld = 1'b1;
                end else begin
                    cnt_next = 2'd1;
                    exp_next = len;
                end
            end else begin
                bundle.tail_vld = 1'b1;
            end
        end
    end

    assign has_result = bundle.tail_vld || (bundle.nrep != '0);

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            exp_reg <= utf8d_pkg::LEN_NONE;
        end else if (fire) begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

    // held bytes
    always_ff @(posedge aclk) begin
        if (fire) begin
            pb_reg[0] <= pb_next[0];
            pb_reg[1] <= pb_next[1];
            pb_reg[2] <= pb_next[2];
        end
    end

    // a held sequence always has room for at least one more byte
    a_cnt_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        pend |-> (({1'b0, cnt_reg} < exp_reg) &&
                  (exp_reg == utf8d_pkg::LEN_TWO || exp_reg == utf8d_pkg::LEN_THREE ||
                   exp_reg == utf8d_pkg::LEN_FOUR)))
        else $error("held count out of step with sequence length");

    // nothing held means no length recorded
    a_empty_no_len: assert property (@(posedge aclk) disable iff (!aresetn)
        !pend |-> (exp_reg == utf8d_pkg::LEN_NONE))
        else $error("sequence length left over with nothing held");

    // an item that ends the string leaves nothing held
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && str_end) |=> !pend)
        else $error("bytes still held after string end");

endmodule

[src/utf8d_emit.sv]
module utf8d_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  utf8d_pkg::bundle_t           bundle,
    output logic                         ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,   // [20:0] code_point
    output logic [1:0]                   m_tuser,   // [0] replaced, [1] run_last
    output logic                         m_tlast    // final_result
);

    logic                          vld_reg, vld_next;
    logic [utf8d_pkg::CNT_W-1:0]   rep_reg, rep_next;
    logic                          tvld_reg;
    logic [utf8d_pkg::CP_W-1:0]    tcp_reg;
    logic                          trep_reg;
    logic                          end_reg;

    logic                          out_last;
    logic                          take;
    logic [utf8d_pkg::CP_W-1:0]    out_cp;
    logic                          out_rep;

    // replacements go out first, then the tail result
    assign out_last = (rep_reg == '0) || (rep_reg == 2'd1 && !tvld_reg);
    assign out_cp   = (rep_reg != '0) ? utf8d_pkg::REPL_CP : tcp_reg;
    assign out_rep  = (rep_reg != '0) ? 1'b1 : trep_reg;
    assign take     = vld_reg && m_tready;
    assign ready    = !vld_reg || (take && out_last);

    assign m_tvalid = vld_reg;
    assign m_tdata  = {3'd0, out_cp};
    assign m_tuser  = {out_last, out_rep};
    assign m_tlast  = out_last && end_reg;

    // result sequencing
    always_comb begin
        vld_next = vld_reg;
        rep_next = rep_reg;
        if (load) begin
            vld_next = 1'b1;
            rep_next = bundle.nrep;
        end else if (take) begin
            if (out_last) begin
                vld_next = 1'b0;
            end else begin
                rep_next = rep_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            rep_reg <= '0;
        end else begin
            vld_reg <= vld_next;
            rep_reg <= rep_next;
        end
    end

    // tail result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            tvld_reg <= bundle.tail_vld;
            tcp_reg  <= bundle.tail_cp;
            trep_reg <= bundle.tail_rep;
            end_reg  <= bundle.str_end;
        end
    end

    // a loaded set of results is never empty
    a_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> (tvld_reg || rep_reg != '0))
        else $error("empty result set held for output");

    // replaced results always carry the replacement character
    a_repl_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg && out_rep) |-> (out_cp == utf8d_pkg::REPL_CP))
        else $error("replaced result without replacement character");

    // a load only happens when the previous set is done
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!vld_reg || (take && out_last)))
        else $error("result set overwritten before delivery");

endmodule

[src/utf8_stream_decoder.sv]
// channel | dir | tdata                  | tuser                   | tlast
// s_      | in  | [7:0] byte_in          | -                       | string_end
// m_      | out | [20:0] code_point      | [0] replaced [1] run_last | final_result
//
// an input byte yields up to four results, which leave one by one on the single
// result port; the next byte is taken only as the last of these results goes out
// results pass from the input register through the decode logic to the output register on m_
// reset clears the sequence state and both valid flags; no clearing pass
// m_tready low holds the current result; one more byte waits in the input register
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,    // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [20:0] code_point
    output logic [1:0]  m_tuser,    // [0] replaced, [1] run_last
    output logic        m_tlast     // final_result
);

    logic                          in_vld_reg, in_vld_next;
    logic [utf8d_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          in_end_reg;

    utf8d_pkg::bundle_t            bundle;
    logic                          has_result;
    logic                          emit_rdy;
    logic                          fire;
    logic                          load;

    // the held item is consumed once the output side can take its results
    assign fire     = in_vld_reg && emit_rdy;
    assign load     = fire && has_result;
    assign s_tready = !in_vld_reg || fire;

    // input register
    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    utf8d_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_in    (in_byte_reg),
        .str_end    (in_end_reg),
        .fire       (fire),
        .bundle     (bundle),
        .has_result (has_result)
    );

    utf8d_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .bundle   (bundle),
        .ready    (emit_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // one byte of a string on the input channel
    typedef struct {
        logic [7:0] byte_val;
        logic       str_end;
        logic       drain;      // hold this byte back until all results are out
    } str_byte_t;

    // one decoded character on the result channel
    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] code_pt;
        logic                       repl;
        logic                       run_last;
        logic                       str_last;
    } char_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] byte_in
    logic        s_tlast = 1'b0;      // string_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [20:0] code_point
    logic [1:0]  m_tuser;             // [0] replaced, [1] run_last
    logic        m_tlast;             // final_result

    utf8_stream_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    str_byte_t  byte_queue[$];
    char_res_t  char_expect[$];
    char_res_t  step_res[$];
    str_byte_t  cur_byte;
    char_res_t  got_char;
    char_res_t  want_char;

    // decoder state as the testbench tracks it
    logic [7:0] held[0:2];
    logic [1:0] held_cnt = 2'd0;
    logic [2:0] need_len = utf8d_pkg::LEN_NONE;

    int  errors = 0;
    int  bytes_taken = 0;
    bit  in_taken = 1'b0;
    bit  rx_hold = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  n_dir;

    task automatic report(input string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        errors++;
    endtask

    // append one expected char of the current byte
    task automatic add_res(input logic [utf8d_pkg::CP_W-1:0] cp, input logic rep);
        step_res.insert(step_res.size(),
                        char_res_t'{code_pt: cp, repl: rep, run_last: 1'b0,
                                    str_last: 1'b0});
    endtask

    // each held byte of a broken sequence becomes a replacement char
    task automatic flush_held();
        for (int k = 0; k < held_cnt; k++) begin
            add_res(utf8d_pkg::REPL_CP, 1'b1);
        end
        held_cnt = 2'd0;
        need_len = utf8d_pkg::LEN_NONE;
    endtask

    // expected chars for one accepted byte, appended to char_expect
    task automatic decode_byte(input logic [7:0] b, input logic str_end);
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic [2:0]                 len;
        bit                         used;
        used = 1'b0;
        step_res.delete();
        if (held_cnt != 2'd0) begin
            if ((b & utf8d_pkg::MASK_CONT) == utf8d_pkg::CONT) begin
                used = 1'b1;
                if (held_cnt + 1 >= need_len) begin
                    // sequence complete: lead bits then six bits per continuation
                    case (need_len)
                        utf8d_pkg::LEN_TWO: begin
                            cp = {13'd0, held[0] & 8'h1F};
                        end
                        utf8d_pkg::LEN_THREE: begin
                            cp = {13'd0, held[0] & 8'h0F};
                        end
                        default: begin
                            cp = {13'd0, held[0] & 8'h07};
                        end
                    endcase
                    for (int k = 1; k < held_cnt; k++) begin
                        cp = {cp[utf8d_pkg::CP_W-7:0], held[k][5:0]};
                    end
                    cp = {cp[utf8d_pkg::CP_W-7:0], b[5:0]};
                    add_res(cp, 1'b0);
                    held_cnt = 2'd0;
                    need_len = utf8d_pkg::LEN_NONE;
                end else begin
                    if (held_cnt < 2'd3) begin
                        held[held_cnt] = b;
                        held_cnt++;
                    end
                    if (str_end) begin
                        flush_held();
                    end
                end
            end else begin
                flush_held();
            end
        end
        if (!used) begin
            len = utf8d_pkg::LEN_NONE;
            if ((b & utf8d_pkg::MASK_2) == utf8d_pkg::LEAD_2) begin
                len = utf8d_pkg::LEN_TWO;
            end else if ((b & utf8d_pkg::MASK_3) == utf8d_pkg::LEAD_3) begin
                len = utf8d_pkg::LEN_THREE;
            end else if ((b & utf8d_pkg::MASK_4) == utf8d_pkg::LEAD_4) begin
                len = utf8d_pkg::LEN_FOUR;
            end
            if (b[7] == 1'b0) begin
                add_res({13'd0, b}, 1'b0);
            end else if (len != utf8d_pkg::LEN_NONE) begin
                held[0] = b;
                held_cnt = 2'd1;
                need_len = len;
                if (str_end) begin
                    flush_held();
                end
            end else begin
                add_res(utf8d_pkg::REPL_CP, 1'b1);
            end
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size()-1].run_last = 1'b1;
            step_res[step_res.size()-1].str_last = str_end;
        end
        foreach (step_res[i]) begin
            char_expect.insert(char_expect.size(), step_res[i]);
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic str_end);
        byte_queue.insert(byte_queue.size(),
                          str_byte_t'{byte_val: b, str_end: str_end, drain: 1'b0});
    endtask

    // one character in utf-8 lead and continuation layout with random payload, sometimes damaged
    task automatic add_char();
        int   len;
        int   fault;
        len = $urandom_range(1, 4);
        fault = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        case (len)
            1: add_byte(8'($urandom_range(0, 127)), 1'b0);
            2: add_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
            3: add_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
            default: add_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        endcase
        // a truncated sequence drops its last continuation
        for (int k = 1; k < len - ((fault == 1) ? 1 : 0); k++) begin
            add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end
        if (fault == 2) begin
            add_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end else if (fault == 3) begin
            add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // input side sampling, prediction and result checking
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) begin
            decode_byte(s_tdata, s_tlast);
            bytes_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_char = '{code_pt: m_tdata[utf8d_pkg::CP_W-1:0], repl: m_tuser[0],
                         run_last: m_tuser[1], str_last: m_tlast};
            if (char_expect.size() == 0) begin
                report($sformatf("unexpected char %06h", got_char.code_pt));
            end else begin
                want_char = char_expect.pop_front();
                if (got_char.code_pt !== want_char.code_pt) begin
                    report($sformatf("code_point %06h, want %06h",
                                     got_char.code_pt, want_char.code_pt));
                end
                if (got_char.repl !== want_char.repl) begin
                    report($sformatf("replaced %b, want %b", got_char.repl, want_char.repl));
                end
                if (got_char.run_last !== want_char.run_last) begin
                    report($sformatf("run_last %b, want %b",
                                     got_char.run_last, want_char.run_last));
                end
                if (got_char.str_last !== want_char.str_last) begin
                    report($sformatf("final_result %b, want %b",
                                     got_char.str_last, want_char.str_last));
                end
            end
        end
    end

    // byte driver with random gaps, none near the end
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_taken) begin
            s_tvalid <= 1'b1;
        end else if (tx_gap > 0) begin
            tx_gap--;
            s_tvalid <= 1'b0;
        end else if (byte_queue.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (byte_queue[0].drain && char_expect.size() != 0) begin
            s_tvalid <= 1'b0;
        end else if (byte_queue.size() > 30 && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(0, 3);
            s_tvalid <= 1'b0;
        end else begin
            cur_byte = byte_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= cur_byte.byte_val;
            s_tlast  <= cur_byte.str_end;
        end
    end

    // result receiver with random stalls and one long hold
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else if (byte_queue.size() > 30 && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long receiver hold so the decoder backs up into its input
    initial begin
        while (bytes_taken < 40) begin
            @(posedge aclk);
        end
        rx_hold = 1'b1;
        repeat (60) @(posedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #200000;
        $display("[utf8_stream_decoder] ERROR");
        $finish;
    end

    initial begin
        // ascii extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        // two, three and four byte sequences, largest four byte value
        add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
        add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // a properly encoded U+FFFD is not a replacement
        add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBD, 1'b1);
        // sequence broken by an ascii byte
        add_byte(8'hE2, 1'b0); add_byte(8'h41, 1'b0);
        // string ends in the middle of a sequence
        add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b1);
        // stray continuation and invalid lead
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        // lone lead byte at string end
        add_byte(8'hC2, 1'b1);
        // three held bytes broken, four results from one byte
        add_byte(8'hF4, 1'b0); add_byte(8'h8F, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'h41, 1'b1);
        n_dir = byte_queue.size();

        // random strings, mostly well formed, some pure noise
        while (byte_queue.size() < n_dir + 125) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    add_char();
                end
                byte_queue[byte_queue.size()-1].str_end = 1'b1;
            end
        end
        byte_queue[n_dir].drain = 1'b1;
        byte_queue[n_dir + 100].drain = 1'b1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for the stimulus and every expected char, then let things settle
        while (byte_queue.size() != 0 || s_tvalid) begin
            @(posedge aclk);
        end
        while (char_expect.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (char_expect.size() != 0) begin
            report($sformatf("%0d chars never arrived", char_expect.size()));
        end
        if (errors == 0) begin
            $display("[utf8_stream_decoder] OK");
        end else begin
            $display("[utf8_stream_decoder] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
src/utf8d_pkg.sv
src/utf8d_decode.sv
src/utf8d_emit.sv
src/utf8_stream_decoder.sv
tb/tb_top.sv
